### rtl/seam_endpoint_extent_macros.svh
// assertion macros shared by the seam endpoint extent rtl
// no dependencies; included by the modules that carry assertions
`ifndef SEAM_ENDPOINT_EXTENT_MACROS_SVH
`define SEAM_ENDPOINT_EXTENT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define SEPX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define SEPX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sepx_pkg.sv
// shared types and constants of the seam endpoint extent block
// no dependencies; imported by every module of the block
package sepx_pkg;

    localparam int COORD_W        = 32;
    localparam int DIR_W          = 32;
    localparam int LIMIT_W        = 31;
    localparam int HITS_W         = 10;
    localparam int CFG_W          = 32;
    localparam int REG_IDX_W      = 3;
    localparam int MAX_POINTS_DEF = 1048576;

    // fraction bits of the direction (q2.30)
    localparam int FRAC = 30;

    // front arithmetic widths
    localparam int V_W     = COORD_W + 1;
    localparam int PROD_W  = V_W + DIR_W - 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int VV_W    = SQ_W + 2;
    localparam int DOT_W   = PROD_W + 2;
    localparam int T_W     = DOT_W - FRAC;
    localparam int TMAG_W  = T_W - 1;
    localparam int TLO_W   = 18;
    localparam int THI_W   = TMAG_W - TLO_W;
    localparam int T2_W    = 2 * TMAG_W;
    localparam int LIM2_W  = 2 * LIMIT_W;
    localparam int BOUND_W = T2_W + 1;

    // back arithmetic widths
    localparam int EHI_W = T_W - TLO_W;
    localparam int PHI_W = EHI_W + DIR_W;
    localparam int PLO_W = TLO_W + 1 + DIR_W;
    localparam int PT_W  = T_W + DIR_W;
    localparam int ES_W  = PT_W - FRAC;
    localparam int EV_W  = ES_W + 1;

    // summary queue and front pipeline depth
    localparam int Q_DEPTH    = 8;
    localparam int Q_IDX_W    = $clog2(Q_DEPTH);
    localparam int QCNT_W     = $clog2(Q_DEPTH + 1);
    localparam int PIPE_DEPTH = 7;
    localparam int LVL_W      = $clog2(Q_DEPTH + PIPE_DEPTH + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] line_point_x;
        logic signed [COORD_W-1:0] line_point_y;
        logic signed [COORD_W-1:0] line_point_z;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
        logic [LIMIT_W-1:0]        distance_limit;
        logic [HITS_W-1:0]         min_hits;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        line_point_x:   '0,
        line_point_y:   '0,
        line_point_z:   '0,
        dir_x:          32'sd1073741824,
        dir_y:          '0,
        dir_z:          '0,
        distance_limit: 31'd131072,
        min_hits:       10'd10
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic                      cloud_end;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] ez;
        logic                      status;
        logic                      is_far_end;
        logic                      run_last;
    } result_t;

    // per cloud summary handed from front to back
    typedef struct packed {
        logic                  fail;
        logic signed [T_W-1:0] t_least;
        logic signed [T_W-1:0] t_greatest;
    } summary_t;

endpackage

### rtl/sepx_front.sv
// front pipeline: offset, projection, distance test and per cloud extent tracking
// depends on sepx_pkg; pushes one summary per cloud into sepx_queue
module sepx_front
    import sepx_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               point_valid,
    output logic               point_ready,
    input  point_t             point,
    input  logic [QCNT_W-1:0]  queue_level,
    output logic               push,
    output summary_t           push_data
);

    localparam int CNT_W = $clog2(2 * MAX_POINTS);
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(2 * MAX_POINTS - 1);
    localparam int CMP_W = (CNT_W > HITS_W) ? CNT_W : HITS_W;
    localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

    logic signed [COORD_W-1:0] lp [3];
    logic signed [DIR_W-1:0]   dir [3];
    logic signed [COORD_W-1:0] pc [3];

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] end_reg;
    logic                  accept;

    // stage 1
    logic signed [V_W-1:0] v_reg [3];
    logic signed [V_W-1:0] v_next [3];
    // stage 2
    logic signed [V_W+DIR_W-1:0] dp_full [3];
    logic signed [2*V_W-1:0]     sq_full [3];
    logic signed [PROD_W-1:0]    prod_reg [3];
    logic [SQ_W-1:0]             sq_reg [3];
    logic [LIM2_W-1:0]           lim2_reg;
    // stage 3
    logic signed [DOT_W-1:0] dot_next;
    logic signed [T_W-1:0]   t3_reg;
    logic [VV_W-1:0]         vv3_reg;
    logic [VV_W-1:0]         vv_next;
    // stage 4
    logic signed [T_W-1:0]        t_neg;
    logic [TMAG_W-1:0]            t_mag;
    logic [THI_W-1:0]             t_hi;
    logic [TLO_W-1:0]             t_lo;
    logic signed [T_W-1:0]        t4_reg;
    logic [VV_W-1:0]              vv4_reg;
    logic [2*THI_W-1:0]           hh_reg;
    logic [THI_W+TLO_W-1:0]       hl_reg;
    logic [2*TLO_W-1:0]           ll_reg;
    // stage 5
    logic signed [T_W-1:0] t5_reg;
    logic [VV_W-1:0]       vv5_reg;
    logic [T2_W-1:0]       t2_reg;
    // stage 6
    logic signed [T_W-1:0] t6_reg;
    logic [VV_W-1:0]       vv6_reg;
    logic [BOUND_W-1:0]    bound_reg;
    // stage 7
    logic signed [T_W-1:0] t7_reg;
    logic                  pass_reg;

    // cloud accumulators
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic signed [T_W-1:0] least_reg;
    logic signed [T_W-1:0] least_next;
    logic signed [T_W-1:0] greatest_reg;
    logic signed [T_W-1:0] greatest_next;
    logic                  hit;
    logic [HITS_W-1:0]     need;
    logic [LVL_W-1:0]      level_sum;

    always_comb
    begin
        lp[0]  = cfg.line_point_x;
        lp[1]  = cfg.line_point_y;
        lp[2]  = cfg.line_point_z;
        dir[0] = cfg.dir_x;
        dir[1] = cfg.dir_y;
        dir[2] = cfg.dir_z;
        pc[0]  = point.px;
        pc[1]  = point.py;
        pc[2]  = point.pz;
    end

    // room for every cloud end already in flight plus this one
    assign level_sum   = LVL_W'(queue_level) + LVL_W'($countones(vld_reg & end_reg));
    assign point_ready = level_sum < LVL_W'(Q_DEPTH);
    assign accept      = point_valid && point_ready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_next[i]  = {pc[i][COORD_W-1], pc[i]} - {lp[i][COORD_W-1], lp[i]};
            dp_full[i] = v_reg[i] * dir[i];
            sq_full[i] = v_reg[i] * v_reg[i];
        end
        dot_next = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2]);
        vv_next  = VV_W'(sq_reg[0]) + VV_W'(sq_reg[1]) + VV_W'(sq_reg[2]);
        t_neg    = -t3_reg;
        t_mag    = t3_reg[T_W-1] ? t_neg[TMAG_W-1:0] : t3_reg[TMAG_W-1:0];
        t_hi     = t_mag[TMAG_W-1:TLO_W];
        t_lo     = t_mag[TLO_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], accept};
        end
    end

    // datapath stages, not gated; the valid chain tracks which stages hold a point
    always_ff @(posedge clk)
    begin
        end_reg  <= {end_reg[PIPE_DEPTH-2:0], point.cloud_end};
        lim2_reg <= cfg.distance_limit * cfg.distance_limit;
        for (int i = 0; i < 3; i++)
        begin
            v_reg[i]    <= v_next[i];
            prod_reg[i] <= dp_full[i][PROD_W-1:0];
            sq_reg[i]   <= sq_full[i][SQ_W-1:0];
        end
        t3_reg    <= dot_next[DOT_W-1:FRAC];
        vv3_reg   <= vv_next;
        t4_reg    <= t3_reg;
        vv4_reg   <= vv3_reg;
        hh_reg    <= t_hi * t_hi;
        hl_reg    <= t_hi * t_lo;
        ll_reg    <= t_lo * t_lo;
        t5_reg    <= t4_reg;
        vv5_reg   <= vv4_reg;
        t2_reg    <= (T2_W'(hh_reg) << (2 * TLO_W)) + (T2_W'(hl_reg) << (TLO_W + 1))
                     + T2_W'(ll_reg);
        t6_reg    <= t5_reg;
        vv6_reg   <= vv5_reg;
        bound_reg <= BOUND_W'(lim2_reg) + BOUND_W'(t2_reg);
        t7_reg    <= t6_reg;
        pass_reg  <= BOUND_W'(vv6_reg) <= bound_reg;
    end

    always_comb
    begin
        hit           = vld_reg[PIPE_DEPTH-1] && pass_reg;
        cnt_next      = (hit && cnt_reg != COUNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
        least_next    = (hit && t7_reg < least_reg) ? t7_reg : least_reg;
        greatest_next = (hit && t7_reg > greatest_reg) ? t7_reg : greatest_reg;
        need          = (cfg.min_hits == '0) ? HITS_W'(1) : cfg.min_hits;
        push          = vld_reg[PIPE_DEPTH-1] && end_reg[PIPE_DEPTH-1];
        push_data.fail       = CMP_W'(cnt_next) < CMP_W'(need);
        push_data.t_least    = least_next;
        push_data.t_greatest = greatest_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            least_reg    <= T_MAX;
            greatest_reg <= T_MIN;
        end
        else if (push)
        begin
            cnt_reg      <= '0;
            least_reg    <= T_MAX;
            greatest_reg <= T_MIN;
        end
        else if (vld_reg[PIPE_DEPTH-1])
        begin
            cnt_reg      <= cnt_next;
            least_reg    <= least_next;
            greatest_reg <= greatest_next;
        end
    end

endmodule

### rtl/sepx_queue.sv
// small first-in first-out queue of cloud summaries between front and back
// depends on sepx_pkg and the assertion macros header
`include "seam_endpoint_extent_macros.svh"

module sepx_queue
    import sepx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  summary_t          push_data,
    input  logic              pop,
    output summary_t          head,
    output logic              empty,
    output logic [QCNT_W-1:0] level
);

    summary_t           entry_reg [Q_DEPTH];
    logic [Q_IDX_W-1:0] wr_ptr_reg;
    logic [Q_IDX_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0]  level_reg;
    logic [QCNT_W-1:0]  level_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SEPX_ASSERT_NOW(a_no_push_full, clk, rst_n, push, level_reg != QCNT_W'(Q_DEPTH), "summary pushed into a full queue")
    `SEPX_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, level_reg != '0, "summary popped from an empty queue")

endmodule

### rtl/sepx_back.sv
// back end: turns a cloud summary into endpoint transactions on the output register
// depends on sepx_pkg and the assertion macros header
`include "seam_endpoint_extent_macros.svh"

module sepx_back
    import sepx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     empty,
    input  summary_t head,
    output logic     pop,
    output logic     result_valid,
    input  logic     result_ready,
    output result_t  result
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MUL  = 3'd1;
    localparam logic [2:0] B_SUM  = 3'd2;
    localparam logic [2:0] B_SAT  = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;

    localparam logic signed [EV_W-1:0] EV_HI =
        {{(EV_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [EV_W-1:0] EV_LO =
        {{(EV_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic                  side_reg;
    logic                  side_next;
    logic                  fail_reg;
    logic signed [T_W-1:0] tl_reg;
    logic signed [T_W-1:0] tg_reg;
    logic                  result_valid_reg;
    logic                  result_valid_next;
    result_t               result_reg;
    result_t               result_next;
    logic                  load;

    logic signed [COORD_W-1:0] lp [3];
    logic signed [DIR_W-1:0]   dir [3];
    logic signed [T_W-1:0]     t_sel;
    logic signed [EHI_W-1:0]   t_hi;
    logic signed [TLO_W:0]     t_lo;
    logic signed [PHI_W-1:0]   phi_reg [3];
    logic signed [PLO_W-1:0]   plo_reg [3];
    logic signed [PT_W-1:0]    pt [3];
    logic signed [ES_W-1:0]    es_reg [3];
    logic signed [EV_W-1:0]    ev [3];
    logic signed [COORD_W-1:0] coord_next [3];
    logic signed [COORD_W-1:0] coord_reg [3];

    always_comb
    begin
        lp[0]  = cfg.line_point_x;
        lp[1]  = cfg.line_point_y;
        lp[2]  = cfg.line_point_z;
        dir[0] = cfg.dir_x;
        dir[1] = cfg.dir_y;
        dir[2] = cfg.dir_z;
        t_sel  = side_reg ? tg_reg : tl_reg;
        t_hi   = t_sel[T_W-1:TLO_W];
        t_lo   = $signed({1'b0, t_sel[TLO_W-1:0]});
        for (int i = 0; i < 3; i++)
        begin
            pt[i] = (PT_W'(phi_reg[i]) <<< TLO_W) + PT_W'(plo_reg[i]);
            ev[i] = EV_W'(es_reg[i]) + EV_W'(lp[i]);
            if (ev[i] > EV_HI)
            begin
                coord_next[i] = EV_HI[COORD_W-1:0];
            end
            else if (ev[i] < EV_LO)
            begin
                coord_next[i] = EV_LO[COORD_W-1:0];
            end
            else
            begin
                coord_next[i] = ev[i][COORD_W-1:0];
            end
        end
    end

    // multiply, floor by the fraction, then offset and clamp
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            phi_reg[i] <= t_hi * dir[i];
            plo_reg[i] <= t_lo * dir[i];
            es_reg[i]  <= pt[i][PT_W-1:FRAC];
            if (state_reg == B_SAT)
            begin
                coord_reg[i] <= coord_next[i];
            end
        end
    end

    assign load = (state_reg == B_OUT) && (!result_valid_reg || result_ready);
    assign pop  = (state_reg == B_IDLE) && !empty;

    always_comb
    begin
        state_next        = state_reg;
        side_next         = side_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    side_next  = 1'b0;
                    state_next = head.fail ? B_OUT : B_MUL;
                end
            end
            B_MUL:
            begin
                state_next = B_SUM;
            end
            B_SUM:
            begin
                state_next = B_SAT;
            end
            B_SAT:
            begin
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (load)
                begin
                    result_valid_next = 1'b1;
                    if (fail_reg)
                    begin
                        result_next = '{ex: '0, ey: '0, ez: '0, status: 1'b1,
                                        is_far_end: 1'b0, run_last: 1'b1};
                        state_next  = B_IDLE;
                    end
                    else
                    begin
                        result_next = '{ex: coord_reg[0], ey: coord_reg[1],
                                        ez: coord_reg[2], status: 1'b0,
                                        is_far_end: side_reg, run_last: side_reg};
                        side_next   = 1'b1;
                        state_next  = side_reg ? B_IDLE : B_MUL;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            side_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            side_reg         <= side_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (pop)
        begin
            fail_reg <= head.fail;
            tl_reg   <= head.t_least;
            tg_reg   <= head.t_greatest;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `SEPX_ASSERT_NOW(a_fail_alone, clk, rst_n, result_valid_reg && result_reg.status, result_reg.run_last && !result_reg.is_far_end, "failure transaction not alone")
    `SEPX_ASSERT_NOW(a_far_is_last, clk, rst_n, result_valid_reg && result_reg.is_far_end, result_reg.run_last, "end endpoint not marked last")
    `SEPX_ASSERT_NEXT(a_start_then_end, clk, rst_n, load && !fail_reg && !side_reg, state_reg == B_MUL && side_reg, "start endpoint not followed by end")

endmodule

### rtl/seam_endpoint_extent.sv
// top level of the seam endpoint extent block: configuration registers and wiring
// depends on sepx_pkg, sepx_front, sepx_queue and sepx_back
//
// Takes the 3-D points of a cloud (Q16.16), one transaction per point, the last one
// flagged with cloud_end. Each point is offset from the configured line point and
// projected on the configured direction (Q2.30, not normalized) to get t; the point
// passes when |v|^2 <= limit^2 + t^2, all exact, no root. Passing points are counted
// (saturating) and the least and greatest t are kept. On the last point the block
// returns the start endpoint (least t) then the end endpoint (greatest t), each
// line_point + floor(t * dir) clamped to 32 bits, or one failure transaction with
// status 1 when fewer than min_hits points passed (min_hits 0 acts as 1); the cloud
// state then clears. Timing: a point is accepted every clock as long as the eight
// entry summary queue, counting the cloud ends still in the seven stage front
// pipeline, has room. A point crosses the seven front stages before it reaches the
// cloud accumulators; the back end, one shared multiply and clamp unit, takes a
// summary and then runs multiply, sum, clamp and output register for each endpoint
// (output register only on failure), so it handles one summary at a time, which
// paces very short clouds. The output register lets the front keep taking points
// while a result waits. Configuration writes are registered and must be made while
// the block is idle.
module seam_endpoint_extent
    import sepx_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 point_valid,
    output logic                 point_ready,
    input  point_t               point,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result
);

    // register indexes of the configuration port
    localparam logic [REG_IDX_W-1:0] REG_LP_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LP_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LP_Z   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DIR_X  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIR_Y  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DIR_Z  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_HITS   = 3'd7;

    cfg_t              cfg_reg;
    logic              push;
    summary_t          push_data;
    logic              pop;
    summary_t          head;
    logic              empty;
    logic [QCNT_W-1:0] level;

    // configuration registers, narrow ones keep their low bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LP_X:  cfg_reg.line_point_x   <= cfg_data;
                REG_LP_Y:  cfg_reg.line_point_y   <= cfg_data;
                REG_LP_Z:  cfg_reg.line_point_z   <= cfg_data;
                REG_DIR_X: cfg_reg.dir_x          <= cfg_data;
                REG_DIR_Y: cfg_reg.dir_y          <= cfg_data;
                REG_DIR_Z: cfg_reg.dir_z          <= cfg_data;
                REG_LIMIT: cfg_reg.distance_limit <= cfg_data[LIMIT_W-1:0];
                REG_HITS:  cfg_reg.min_hits       <= cfg_data[HITS_W-1:0];
                default:   cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // front: per point arithmetic and cloud tracking
    sepx_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .queue_level (level),
        .push        (push),
        .push_data   (push_data)
    );

    // summaries wait here while the back end drains results
    sepx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .level     (level)
    );

    // back: endpoint reconstruction and output register
    sepx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### verif/sepx_checker.sv
// endpoint predictor and result checker for the seam endpoint extent block
// depends on sepx_pkg; also holds sepx_tb_pkg, the register indexes shared with the testbench top
package sepx_tb_pkg;
    import sepx_pkg::*;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LINE_X,
        REG_LINE_Y,
        REG_LINE_Z,
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z,
        REG_LIMIT,
        REG_MIN_HITS
    } reg_idx_t;
endpackage

module sepx_checker
    import sepx_pkg::*;
    import sepx_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 point_valid,
    input  logic                 point_ready,
    input  point_t               point,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  result_t              result,
    output int                   errors,
    output int                   pending
);

    typedef logic signed [127:0] acc_t;

    localparam acc_t COORD_HI = (acc_t'(1) <<< (COORD_W - 1)) - 1;
    localparam acc_t COORD_LO = -COORD_HI - 1;
    localparam logic signed [39:0] T_TOP    = {1'b0, {39{1'b1}}};
    localparam logic signed [39:0] T_BOTTOM = {1'b1, {39{1'b0}}};
    localparam int MAX_REPORTS = 10;

    cfg_t               setting;
    logic [20:0]        hits;
    logic signed [39:0] t_low;
    logic signed [39:0] t_high;
    result_t            endpoints_due[$];
    int                 mismatches;

    function automatic void clear_cloud();
        hits   = '0;
        t_low  = T_TOP;
        t_high = T_BOTTOM;
    endfunction

    // base + floor(t * dir), clamped to the coordinate range
    function automatic logic signed [COORD_W-1:0] place_on_line(
        acc_t t, logic signed [COORD_W-1:0] base, logic signed [DIR_W-1:0] d);
        acc_t sum;
        sum = acc_t'(base) + ((t * acc_t'(d)) >>> FRAC);
        if (sum > COORD_HI)
            sum = COORD_HI;
        if (sum < COORD_LO)
            sum = COORD_LO;
        return sum[COORD_W-1:0];
    endfunction

    task automatic fold_point(input point_t p);
        acc_t        coord [3];
        acc_t        base [3];
        acc_t        d [3];
        acc_t        off;
        acc_t        dot;
        acc_t        mag2;
        acc_t        t;
        acc_t        lim;
        logic [20:0] need;
        result_t     r;
        int          i;
        coord[0] = acc_t'($signed(p.px));
        coord[1] = acc_t'($signed(p.py));
        coord[2] = acc_t'($signed(p.pz));
        base[0]  = acc_t'($signed(setting.line_point_x));
        base[1]  = acc_t'($signed(setting.line_point_y));
        base[2]  = acc_t'($signed(setting.line_point_z));
        d[0]     = acc_t'($signed(setting.dir_x));
        d[1]     = acc_t'($signed(setting.dir_y));
        d[2]     = acc_t'($signed(setting.dir_z));
        dot  = '0;
        mag2 = '0;
        for (i = 0; i < 3; i++)
        begin
            off  = coord[i] - base[i];
            dot  = dot + off * d[i];
            mag2 = mag2 + off * off;
        end
        t   = dot >>> FRAC;
        lim = acc_t'(setting.distance_limit);
        // squared perpendicular distance against squared limit, no root
        if (mag2 <= lim * lim + t * t)
        begin
            if (hits != '1)
                hits = hits + 1'b1;
            if (t < t_low)
                t_low = t[39:0];
            if (t > t_high)
                t_high = t[39:0];
        end
        if (!p.cloud_end)
            return;
        need = (setting.min_hits == '0) ? 21'd1 : 21'(setting.min_hits);
        r = '0;
        if (hits < need)
        begin
            r.status   = 1'b1;
            r.run_last = 1'b1;
            endpoints_due.insert(endpoints_due.size(), r);
        end
        else
        begin
            r.ex = place_on_line(t_low, setting.line_point_x, setting.dir_x);
            r.ey = place_on_line(t_low, setting.line_point_y, setting.dir_y);
            r.ez = place_on_line(t_low, setting.line_point_z, setting.dir_z);
            endpoints_due.insert(endpoints_due.size(), r);
            r.ex         = place_on_line(t_high, setting.line_point_x, setting.dir_x);
            r.ey         = place_on_line(t_high, setting.line_point_y, setting.dir_y);
            r.ez         = place_on_line(t_high, setting.line_point_z, setting.dir_z);
            r.is_far_end = 1'b1;
            r.run_last   = 1'b1;
            endpoints_due.insert(endpoints_due.size(), r);
        end
        clear_cloud();
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (endpoints_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: unexpected result ex=%0d ey=%0d ez=%0d status=%0b far=%0b last=%0b",
                         $time, got.ex, got.ey, got.ez, got.status,
                         got.is_far_end, got.run_last);
            return;
        end
        want = endpoints_due.pop_front();
        if (got.ex !== want.ex || got.ey !== want.ey || got.ez !== want.ez ||
            got.status !== want.status || got.is_far_end !== want.is_far_end ||
            got.run_last !== want.run_last)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("%0t: result mismatch", $time);
                $display("  expected ex=%0d ey=%0d ez=%0d status=%0b far=%0b last=%0b",
                         want.ex, want.ey, want.ez, want.status, want.is_far_end,
                         want.run_last);
                $display("  actual   ex=%0d ey=%0d ez=%0d status=%0b far=%0b last=%0b",
                         got.ex, got.ey, got.ez, got.status, got.is_far_end,
                         got.run_last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setting = CFG_RESET;
            clear_cloud();
            endpoints_due.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_LINE_X:   setting.line_point_x   = cfg_data[COORD_W-1:0];
                    REG_LINE_Y:   setting.line_point_y   = cfg_data[COORD_W-1:0];
                    REG_LINE_Z:   setting.line_point_z   = cfg_data[COORD_W-1:0];
                    REG_DIR_X:    setting.dir_x          = cfg_data[DIR_W-1:0];
                    REG_DIR_Y:    setting.dir_y          = cfg_data[DIR_W-1:0];
                    REG_DIR_Z:    setting.dir_z          = cfg_data[DIR_W-1:0];
                    REG_LIMIT:    setting.distance_limit = cfg_data[LIMIT_W-1:0];
                    REG_MIN_HITS: setting.min_hits       = cfg_data[HITS_W-1:0];
                    default:      ;
                endcase
            end
            if (point_valid && point_ready)
                fold_point(point);
            if (result_valid && result_ready)
                check_result(result);
            errors  <= mismatches;
            pending <= endpoints_due.size();
        end
    end

endmodule

### verif/testbench.sv
// testbench top for the seam endpoint extent block: clock, reset, stimulus and verdict
// depends on sepx_pkg, sepx_tb_pkg and sepx_checker (verif/sepx_checker.sv)
module testbench;
    import sepx_pkg::*;
    import sepx_tb_pkg::*;

    // cycles with no transaction on either channel before the run is called hung
    localparam int WATCHDOG_LIMIT = 3000;
    // idle time after the last result before a register write or the verdict;
    // covers the front pipeline plus the back end of one cloud
    localparam int SETTLE_CYCLES  = 24;
    // long receiver hold-off so the summary queue fills and the input stalls
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_POINTS   = 88;
    localparam int PRESSURE_POINTS = 60;
    localparam longint ONE_Q30    = 64'sd1073741824;

    typedef enum { SET_TYPICAL, SET_TOP, SET_BOTTOM } setting_kind_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    reg_idx_t             cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 point_valid;
    logic                 point_ready;
    point_t               point;
    logic                 result_valid;
    logic                 result_ready;
    result_t              result;

    int errors;
    int pending;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_req  = 0;
    int idle_cycles  = 0;
    // points accepted in the current stretch of stimulus
    int sent         = 0;

    seam_endpoint_extent uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point        (point),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // watches both channels and the register port, predicts every result and compares
    sepx_checker extent_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point        (point),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog: any transaction on either side restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((point_valid && point_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls per the current idling mode, plus an optional
    // long hold-off counted here so the sender can keep pushing meanwhile
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= !(rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
        end
    end

    function automatic point_t make_point(logic signed [COORD_W-1:0] x,
                                          logic signed [COORD_W-1:0] y,
                                          logic signed [COORD_W-1:0] z, logic last);
        point_t p;
        p.px        = x;
        p.py        = y;
        p.pz        = z;
        p.cloud_end = last;
        return p;
    endfunction

    // offers one point; an idle gap, if any, comes before valid is raised,
    // and valid stays high after acceptance so back-to-back transactions need no toggle
    task automatic put_point(input point_t p);
        int gap;
        gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point       <= p;
        point_valid <= 1'b1;
        do
            @(posedge clk);
        while (!point_ready);
        sent++;
    endtask

    // stop offering and wait until the checker has nothing outstanding;
    // pending is registered, hence the first clock before looking
    task automatic wait_drained();
        point_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // all eight registers back to back; the unused upper data bits carry junk
    task automatic write_setting(input cfg_t c);
        logic [CFG_W-1:0] vals [8];
        int               i;
        vals[0] = c.line_point_x;
        vals[1] = c.line_point_y;
        vals[2] = c.line_point_z;
        vals[3] = c.dir_x;
        vals[4] = c.dir_y;
        vals[5] = c.dir_z;
        vals[6] = {1'($urandom), c.distance_limit};
        vals[7] = {22'($urandom), c.min_hits};
        for (i = 0; i < $size(vals); i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // registers only change with the block idle: drained, then the settle time
    task automatic settle_and_write(input cfg_t c);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_setting(c);
    endtask

    function automatic cfg_t pick_setting(setting_kind_t kind);
        cfg_t   c;
        longint lp [3];
        longint d [3];
        int     i;
        int     axis;
        c = CFG_RESET;
        case (kind)
            SET_TOP:
            begin
                // line point, limit and min_hits at the top of their range; min_hits max makes every cloud fail
                for (i = 0; i < 3; i++)
                begin
                    lp[i] = 64'sh7FFF_FFFF;
                    d[i]  = ONE_Q30;
                end
                c.distance_limit = '1;
                c.min_hits       = '1;
            end
            SET_BOTTOM:
            begin
                // non-unit negative direction, zero limit: near-line points still pass
                for (i = 0; i < 3; i++)
                begin
                    lp[i] = -64'sh8000_0000;
                    d[i]  = -ONE_Q30;
                end
                c.distance_limit = '0;
                c.min_hits       = 10'd1;
            end
            default:
            begin
                for (i = 0; i < 3; i++)
                begin
                    if ($urandom_range(3) == 0)
                        lp[i] = longint'($signed($urandom));
                    else
                        lp[i] = longint'($urandom_range(0, 32'h0080_0000)) - 64'sh40_0000;
                    d[i] = 0;
                end
                axis = $urandom_range(2);
                case ($urandom_range(2))
                    0:
                        // unit vector along one axis, either sign
                        d[axis] = $urandom_range(1) ? ONE_Q30 : -ONE_Q30;
                    1:
                        // arbitrary components, generally not unit length
                        for (i = 0; i < 3; i++)
                            d[i] = longint'($urandom_range(0, 32'h8000_0000)) - ONE_Q30;
                    default:
                    begin
                        // unit 3-4-5 direction in a random plane
                        d[axis]           = $urandom_range(1) ? 644245094 : -644245094;
                        d[(axis + 1) % 3] = $urandom_range(1) ? 858993459 : -858993459;
                    end
                endcase
                c.distance_limit = LIMIT_W'($urandom_range(0, 32'h0010_0000));
                c.min_hits       = HITS_W'($urandom_range(1, 12));
            end
        endcase
        c.line_point_x = 32'(lp[0]);
        c.line_point_y = 32'(lp[1]);
        c.line_point_z = 32'(lp[2]);
        c.dir_x        = 32'(d[0]);
        c.dir_y        = 32'(d[1]);
        c.dir_z        = 32'(d[2]);
        return c;
    endfunction

    // a point around the configured line: random position t along it and
    // noise per axis of about the distance limit, so roughly half pass
    function automatic point_t near_point(cfg_t c, logic last);
        longint                    lp [3];
        longint                    d [3];
        logic signed [COORD_W-1:0] xyz [3];
        longint                    t;
        longint                    amp;
        longint                    v;
        int                        i;
        lp[0] = longint'($signed(c.line_point_x));
        lp[1] = longint'($signed(c.line_point_y));
        lp[2] = longint'($signed(c.line_point_z));
        d[0]  = longint'($signed(c.dir_x));
        d[1]  = longint'($signed(c.dir_y));
        d[2]  = longint'($signed(c.dir_z));
        if ($urandom_range(15) == 0)
            t = longint'($signed($urandom));
        else
            t = longint'($urandom_range(0, 32'h0200_0000)) - 64'sh100_0000;
        amp = longint'(c.distance_limit);
        for (i = 0; i < 3; i++)
        begin
            v = lp[i] + ((t * d[i]) >>> 30) + longint'($urandom_range(0, 32'(2 * amp))) - amp;
            if (v > 64'sh7FFF_FFFF)
                v = 64'sh7FFF_FFFF;
            if (v < -64'sh8000_0000)
                v = -64'sh8000_0000;
            xyz[i] = 32'(v);
        end
        return make_point(xyz[0], xyz[1], xyz[2], last);
    endfunction

    // one well-formed cloud: mostly near-line points, some fully random noise,
    // the final point carrying cloud_end
    task automatic send_cloud(input cfg_t c, input int len);
        point_t p;
        int     k;
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(4) == 0)
                p = make_point($urandom, $urandom, $urandom, k == len - 1);
            else
                p = near_point(c, k == len - 1);
            put_point(p);
        end
    endtask

    initial
    begin
        cfg_t plan;
        int   mode;
        int   part;
        int   len;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_LINE_X;
        cfg_data    <= '0;
        point_valid <= 1'b0;
        point       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset settings (line along x, limit 2.0, ten hits needed):
        // coordinate extremes, a point exactly on the limit, one just past it,
        // far points; ten of the twelve pass, so exactly enough for endpoints
        put_point(make_point(32'sh7FFF_FFFF, 0, 0, 1'b0));
        put_point(make_point(32'sh8000_0000, 0, 0, 1'b0));
        put_point(make_point(0, 131072, 0, 1'b0));
        put_point(make_point(0, 0, -131072, 1'b0));
        put_point(make_point(65536, 131073, 0, 1'b0));
        put_point(make_point(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0));
        put_point(make_point(-65536, 92681, 92681, 1'b0));
        put_point(make_point(4096, -5, 7, 1'b0));
        put_point(make_point(8192, 0, -65536, 1'b0));
        put_point(make_point(-12288, 65536, 65536, 1'b0));
        put_point(make_point(16384, 0, 0, 1'b0));
        put_point(make_point(12345, -100, 100, 1'b1));
        // single-point clouds with too few hits: one passing, one not
        put_point(make_point(0, 0, 0, 1'b1));
        put_point(make_point(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1));

        // non-unit diagonal direction, zero limit and zero min_hits (acts as one)
        plan                = CFG_RESET;
        plan.line_point_x   = 32'sh4000_0000;
        plan.line_point_y   = -32'sh4000_0000;
        plan.dir_x          = 32'(ONE_Q30);
        plan.dir_y          = 32'(ONE_Q30);
        plan.distance_limit = '0;
        plan.min_hits       = '0;
        settle_and_write(plan);
        // off the line with t zero: fails, and an empty pass count still fails
        put_point(make_point(32'sh4001_0000, -32'sh4001_0000, 0, 1'b1));
        // negative |v|^2 - t^2 passes; endpoints saturate at both ends
        put_point(make_point(32'sh7FFF_FFFF, -1, 0, 1'b0));
        put_point(make_point(0, 32'sh8000_0000, 0, 1'b0));
        put_point(make_point(32'sh4001_0000, -32'sh3FFF_0000, 0, 1'b1));

        // widest limit with the largest min_hits: a short cloud must fail
        plan                = CFG_RESET;
        plan.line_point_x   = 32'sh7FFF_FFFF;
        plan.line_point_y   = 32'sh8000_0000;
        plan.line_point_z   = 32'sh7FFF_FFFF;
        plan.dir_x          = 32'(-ONE_Q30);
        plan.distance_limit = '1;
        plan.min_hits       = '1;
        settle_and_write(plan);
        put_point(make_point(0, 0, 0, 1'b0));
        put_point(make_point(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1'b0));
        put_point(make_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678, 1'b1));

        // random clouds under four idling modes, two settings each:
        // none, sender idle 72%, receiver stalling 72%, both 7%
        for (mode = 0; mode < 4; mode++)
        begin
            for (part = 0; part < 2; part++)
            begin
                if (mode == 1 && part == 0)
                    plan = pick_setting(SET_TOP);
                else if (mode == 2 && part == 1)
                    plan = pick_setting(SET_BOTTOM);
                else
                    plan = pick_setting(SET_TYPICAL);
                settle_and_write(plan);
                tx_idle_pct  = (mode == 1) ? 72 : (mode == 3) ? 7 : 0;
                rx_stall_pct = (mode == 2) ? 72 : (mode == 3) ? 7 : 0;
                sent = 0;
                while (sent < PHASE_POINTS)
                begin
                    len = ($urandom_range(7) == 0) ? $urandom_range(17, 48)
                                                   : $urandom_range(1, 16);
                    send_cloud(plan, len);
                end
            end
        end

        // back-pressure: the receiver holds off while the sender streams
        // one- and two-point clouds, so summaries pile up and the input stalls
        plan          = pick_setting(SET_TYPICAL);
        plan.min_hits = 10'd1;
        settle_and_write(plan);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = HOLD_CYCLES;
        sent = 0;
        while (sent < PRESSURE_POINTS)
            send_cloud(plan, $urandom_range(1, 2));

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
